// File: rtl/core/kpd_pkg.sv
// Shared constants, types and the div3 helper of the knock pattern detector.
`default_nettype none
package kpd_pkg;

    localparam int STORE_DEPTH = 128;
    localparam int WIN_LEN     = 4;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int FILL_W      = $clog2(STORE_DEPTH + 1);
    localparam int SAMPLE_W    = 8;
    localparam int WAIT_W      = 10;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 10;

    localparam logic [WAIT_W-1:0]   LISTEN_WAIT_RST  = 10'd500;
    localparam logic [7:0]          KEEP_THR_RST     = 8'd80;
    localparam logic [7:0]          HIT_THR_RST      = 8'd70;
    localparam logic [7:0]          SEG_LEN_RST      = 8'd50;
    localparam logic [FILL_W-1:0]   FILL_RST         = FILL_W'(2);
    localparam logic [7:0]          KNOCK_MAX        = 8'd254;
    localparam logic [7:0]          HIT_CODE         = 8'd255;
    localparam logic [7:0]          ZERO_CODE        = 8'd0;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LISTEN_WAIT = 3'd0,
        CFG_KEEP_THR    = 3'd1,
        CFG_HIT_THR     = 3'd2,
        CFG_SEG_LEN     = 3'd3
    } cfg_idx_t;

    typedef enum logic [8:0] {
        ST_IDLE      = 9'b000000001,
        ST_DECIDE    = 9'b000000010,
        ST_MAX_RD    = 9'b000000100,
        ST_MAX_DRAIN = 9'b000001000,
        ST_LOAD_TH   = 9'b000010000,
        ST_CNT_RD    = 9'b000100000,
        ST_CNT_DRAIN = 9'b001000000,
        ST_CNT_FINAL = 9'b010000000,
        ST_DONE      = 9'b100000000
    } state_t;

    typedef enum logic [1:0] {
        RES_ZERO  = 2'd0,
        RES_HIT   = 2'd1,
        RES_COUNT = 2'd2
    } res_sel_t;

    typedef struct packed {
        logic sample_step;
        logic restart;
        logic count_init;
        logic addr_clr;
        logic rd_en;
        logic rd_count;
        logic load_th;
        logic final_eval;
    } cmd_t;

    typedef struct packed {
        logic       hit;
        logic       silence_zero;
        logic       addr_last;
        logic [7:0] count;
    } status_t;

    // Floor of x / 3 for 8-bit x by a reciprocal multiply; exact over the range.
    function automatic logic [7:0] div3(input logic [7:0] x);
        logic [15:0] prod;
        prod = 16'(x) * 16'd171;
        return {1'b0, prod[15:9]};
    endfunction

endpackage
`default_nettype wire

// File: rtl/core/knock_pattern_detector_unit.sv
// Top level of the knock pattern detector: controller and datapath.
//
// Input channel (in_valid/in_ready, kind, sample): kind 0 carries an amplitude
// sample, kind 1 restarts listening. Every sample item yields one result item
// on the output channel (out_valid/out_ready, result_code); a restart yields none.
// result_code is 255 for a hit, the knock count (0 to 254) once silence has run
// out, and 0 otherwise.
// A knock count scans the stored peaks (2 to 128) twice through the store's single
// read port, one entry a cycle: once for the maximum, once for the rises.
// One item is in work at a time; in_ready is high only while the block is idle.
// A new item is accepted while an earlier result still waits in the output register;
// if the receiver stalls, a finished result holds the block until the output register
// frees. Reset restores the register defaults and the restart state. Configuration
// (cfg_we, cfg_index, cfg_data) is to be written by the user only while the block
// is idle; the block itself does not enforce this.
`default_nettype none
module knock_pattern_detector_unit (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             in_valid,
    output logic                                  in_ready,
    input  wire logic                             kind,
    input  wire logic [kpd_pkg::SAMPLE_W-1:0]     sample,
    output logic                                  out_valid,
    input  wire logic                             out_ready,
    output logic [7:0]                            result_code,
    input  wire logic                             cfg_we,
    input  wire logic [kpd_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [kpd_pkg::CFG_DATA_W-1:0]   cfg_data
);

    kpd_pkg::cmd_t    cmd;
    kpd_pkg::status_t status;

    kpd_controller u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .kind        (kind),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .result_code (result_code),
        .cmd         (cmd),
        .status      (status)
    );

    kpd_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .sample    (sample),
        .cmd       (cmd),
        .status    (status)
    );

endmodule
`default_nettype wire

// File: rtl/core/kpd_datapath.sv
// Datapath: configuration, segment and silence tracking, peak store and knock counting.
`default_nettype none
module kpd_datapath (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             cfg_we,
    input  wire logic [kpd_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [kpd_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  wire logic [kpd_pkg::SAMPLE_W-1:0]     sample,
    input  wire kpd_pkg::cmd_t                    cmd,
    output kpd_pkg::status_t                      status
);

    logic [kpd_pkg::WAIT_W-1:0]  listen_wait_reg;
    logic [7:0]                  keep_thr_reg;
    logic [7:0]                  hit_thr_reg;
    logic [7:0]                  seg_len_reg;

    logic [kpd_pkg::WAIT_W-1:0]  silence_reg, silence_next;
    logic [7:0]                  seg_cnt_reg, seg_cnt_next;
    logic [7:0]                  peak_reg, peak_next;
    logic [kpd_pkg::FILL_W-1:0]  fill_reg, fill_next;
    logic [7:0]                  win_reg [kpd_pkg::WIN_LEN];
    logic [7:0]                  win_next [kpd_pkg::WIN_LEN];
    logic                        hit_reg, hit_next;
    logic                        seg_end;
    logic                        store_wr;
    logic [kpd_pkg::WAIT_W-1:0]  silence_load;

    logic [7:0]                  mem [kpd_pkg::STORE_DEPTH];
    logic [kpd_pkg::ADDR_W-1:0]  addr_reg;
    logic [kpd_pkg::ADDR_W-1:0]  fill_last;
    logic [7:0]                  rdata_reg;
    logic                        rvalid_reg;
    logic                        rcount_reg;
    logic                        rzero_reg;
    logic [7:0]                  rd_word;

    logic [7:0]                  top_reg;
    logic [7:0]                  th_reg;
    logic [7:0]                  x_reg, y_reg;
    logic [1:0]                  seen_reg;
    logic [7:0]                  count_reg;

    logic                        eval_en;
    logic                        has_c;
    logic [7:0]                  ev_c;
    logic signed [9:0]           d_ab, d_ac, d_sel;
    logic signed [9:0]           half_s, th_s;
    logic                        knock;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            listen_wait_reg <= kpd_pkg::LISTEN_WAIT_RST;
            keep_thr_reg    <= kpd_pkg::KEEP_THR_RST;
            hit_thr_reg     <= kpd_pkg::HIT_THR_RST;
            seg_len_reg     <= kpd_pkg::SEG_LEN_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                kpd_pkg::CFG_LISTEN_WAIT: listen_wait_reg <= cfg_data[kpd_pkg::WAIT_W-1:0];
                kpd_pkg::CFG_KEEP_THR:    keep_thr_reg    <= cfg_data[7:0];
                kpd_pkg::CFG_HIT_THR:     hit_thr_reg     <= cfg_data[7:0];
                kpd_pkg::CFG_SEG_LEN:     seg_len_reg     <= cfg_data[7:0];
                default:                  ;
            endcase
        end
    end

    // Per-sample update of the segment, window and silence state.
    always_comb
    begin
        seg_cnt_next = seg_cnt_reg + 8'd1;
        seg_end      = (seg_cnt_next == seg_len_reg);
        if (seg_end)
        begin
            seg_cnt_next = 8'd0;
        end
        store_wr  = seg_end && (fill_reg < kpd_pkg::FILL_W'(kpd_pkg::STORE_DEPTH));
        fill_next = store_wr ? fill_reg + kpd_pkg::FILL_W'(1) : fill_reg;

        for (int i = 0; i < kpd_pkg::WIN_LEN; i++)
        begin
            win_next[i] = win_reg[i];
        end
        hit_next = 1'b0;
        if (seg_end)
        begin
            for (int i = 0; i < kpd_pkg::WIN_LEN - 1; i++)
            begin
                win_next[i] = win_reg[i + 1];
            end
            win_next[kpd_pkg::WIN_LEN - 1] = peak_reg;
            hit_next = 1'b1;
            for (int i = 0; i < kpd_pkg::WIN_LEN; i++)
            begin
                if (win_next[i] < hit_thr_reg)
                begin
                    hit_next = 1'b0;
                end
            end
        end

        if (seg_end)
        begin
            peak_next = sample;
        end
        else
        begin
            peak_next = (sample > peak_reg) ? sample : peak_reg;
        end

        silence_load = (sample > keep_thr_reg) ? listen_wait_reg : silence_reg;
        silence_next = (silence_load != '0) ? silence_load - kpd_pkg::WAIT_W'(1) : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            silence_reg <= kpd_pkg::LISTEN_WAIT_RST;
            seg_cnt_reg <= '0;
            peak_reg    <= '0;
            fill_reg    <= kpd_pkg::FILL_RST;
            hit_reg     <= 1'b0;
            for (int i = 0; i < kpd_pkg::WIN_LEN; i++)
            begin
                win_reg[i] <= '0;
            end
        end
        else if (cmd.restart)
        begin
            silence_reg <= listen_wait_reg;
            seg_cnt_reg <= '0;
            peak_reg    <= '0;
            fill_reg    <= kpd_pkg::FILL_RST;
            hit_reg     <= 1'b0;
            for (int i = 0; i < kpd_pkg::WIN_LEN; i++)
            begin
                win_reg[i] <= '0;
            end
        end
        else if (cmd.sample_step)
        begin
            silence_reg <= silence_next;
            seg_cnt_reg <= seg_cnt_next;
            peak_reg    <= peak_next;
            fill_reg    <= fill_next;
            hit_reg     <= hit_next;
            for (int i = 0; i < kpd_pkg::WIN_LEN; i++)
            begin
                win_reg[i] <= win_next[i];
            end
        end
    end

    // Peak store. Entries 0 and 1 are never written; they read as zero.
    always_ff @(posedge clk)
    begin
        if (cmd.sample_step && store_wr)
        begin
            mem[fill_reg[kpd_pkg::ADDR_W-1:0]] <= peak_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.rd_en)
        begin
            rdata_reg <= mem[addr_reg];
        end
    end

    assign fill_last = kpd_pkg::ADDR_W'(fill_reg - kpd_pkg::FILL_W'(1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            addr_reg   <= '0;
            rvalid_reg <= 1'b0;
            rcount_reg <= 1'b0;
            rzero_reg  <= 1'b0;
        end
        else
        begin
            rvalid_reg <= cmd.rd_en;
            rcount_reg <= cmd.rd_count;
            rzero_reg  <= (addr_reg < kpd_pkg::ADDR_W'(2));
            if (cmd.count_init || cmd.addr_clr)
            begin
                addr_reg <= '0;
            end
            else if (cmd.rd_en)
            begin
                addr_reg <= addr_reg + kpd_pkg::ADDR_W'(1);
            end
        end
    end

    assign rd_word = rzero_reg ? 8'd0 : rdata_reg;

    // Pair test: rise x to y; if over th/2, a further rise to the next entry adds on.
    always_comb
    begin
        has_c   = rvalid_reg && rcount_reg && (seen_reg == 2'd2);
        eval_en = has_c || cmd.final_eval;
        ev_c    = rd_word;
        half_s  = $signed({3'b000, th_reg[7:1]});
        th_s    = $signed({2'b00, th_reg});
        d_ab    = $signed({2'b00, y_reg}) - $signed({2'b00, x_reg});
        d_ac    = $signed({2'b00, ev_c}) - $signed({2'b00, x_reg});
        if (has_c && (d_ab > half_s) && (ev_c > y_reg))
        begin
            d_sel = d_ac;
        end
        else
        begin
            d_sel = d_ab;
        end
        knock = eval_en && (d_sel > th_s) && (count_reg < kpd_pkg::KNOCK_MAX);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            top_reg   <= '0;
            th_reg    <= '0;
            seen_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (cmd.count_init)
            begin
                top_reg   <= '0;
                seen_reg  <= '0;
                count_reg <= '0;
            end
            else
            begin
                if (rvalid_reg && !rcount_reg && (rd_word > top_reg))
                begin
                    top_reg <= rd_word;
                end
                if (rvalid_reg && rcount_reg && (seen_reg != 2'd2))
                begin
                    seen_reg <= seen_reg + 2'd1;
                end
                if (knock)
                begin
                    count_reg <= count_reg + 8'd1;
                end
            end
            if (cmd.load_th)
            begin
                th_reg <= kpd_pkg::div3(top_reg);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rvalid_reg && rcount_reg)
        begin
            x_reg <= y_reg;
            y_reg <= rd_word;
        end
    end

    assign status.hit          = hit_reg;
    assign status.silence_zero = (silence_reg == '0);
    assign status.addr_last    = (addr_reg == fill_last);
    assign status.count        = count_reg;

    ap_fill_range: assert property (@(posedge clk) disable iff (!rst_n)
        (fill_reg >= kpd_pkg::FILL_RST) &&
        (fill_reg <= kpd_pkg::FILL_W'(kpd_pkg::STORE_DEPTH)))
        else $error("store fill out of range");

    ap_count_sat: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= kpd_pkg::KNOCK_MAX)
        else $error("knock count above saturation");

    ap_restart_fill: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.restart |=> (fill_reg == kpd_pkg::FILL_RST) && (seg_cnt_reg == 8'd0))
        else $error("restart did not clear the store fill");

endmodule
`default_nettype wire

// File: rtl/core/kpd_controller.sv
// Controller: item handshake, count sequencing and the output register.
`default_nettype none
module kpd_controller (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire logic                 kind,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output logic [7:0]                result_code,
    output kpd_pkg::cmd_t             cmd,
    input  wire kpd_pkg::status_t     status
);

    kpd_pkg::state_t   state_reg, state_next;
    kpd_pkg::res_sel_t sel_reg, sel_next;
    logic              out_valid_reg, out_valid_next;
    logic [7:0]        code_reg, code_next;
    logic              in_acc;
    logic              out_free;

    assign in_ready = (state_reg == kpd_pkg::ST_IDLE);
    assign in_acc   = in_valid && in_ready;
    assign out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next     = state_reg;
        sel_next       = sel_reg;
        out_valid_next = out_valid_reg && !out_ready;
        code_next      = code_reg;
        cmd            = '0;

        case (state_reg)
            kpd_pkg::ST_IDLE:
            begin
                if (in_acc)
                begin
                    if (kind)
                    begin
                        cmd.restart = 1'b1;
                    end
                    else
                    begin
                        cmd.sample_step = 1'b1;
                        state_next      = kpd_pkg::ST_DECIDE;
                    end
                end
            end
            kpd_pkg::ST_DECIDE:
            begin
                if (status.hit)
                begin
                    sel_next   = kpd_pkg::RES_HIT;
                    state_next = kpd_pkg::ST_DONE;
                end
                else if (status.silence_zero)
                begin
                    sel_next       = kpd_pkg::RES_COUNT;
                    cmd.count_init = 1'b1;
                    state_next     = kpd_pkg::ST_MAX_RD;
                end
                else
                begin
                    sel_next   = kpd_pkg::RES_ZERO;
                    state_next = kpd_pkg::ST_DONE;
                end
            end
            kpd_pkg::ST_MAX_RD:
            begin
                cmd.rd_en = 1'b1;
                if (status.addr_last)
                begin
                    state_next = kpd_pkg::ST_MAX_DRAIN;
                end
            end
            kpd_pkg::ST_MAX_DRAIN:
            begin
                state_next = kpd_pkg::ST_LOAD_TH;
            end
            kpd_pkg::ST_LOAD_TH:
            begin
                cmd.load_th  = 1'b1;
                cmd.addr_clr = 1'b1;
                state_next   = kpd_pkg::ST_CNT_RD;
            end
            kpd_pkg::ST_CNT_RD:
            begin
                cmd.rd_en    = 1'b1;
                cmd.rd_count = 1'b1;
                if (status.addr_last)
                begin
                    state_next = kpd_pkg::ST_CNT_DRAIN;
                end
            end
            kpd_pkg::ST_CNT_DRAIN:
            begin
                state_next = kpd_pkg::ST_CNT_FINAL;
            end
            kpd_pkg::ST_CNT_FINAL:
            begin
                // The last pair has no entry after it.
                cmd.final_eval = 1'b1;
                state_next     = kpd_pkg::ST_DONE;
            end
            kpd_pkg::ST_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    case (sel_reg)
                        kpd_pkg::RES_HIT:   code_next = kpd_pkg::HIT_CODE;
                        kpd_pkg::RES_COUNT: code_next = status.count;
                        default:            code_next = kpd_pkg::ZERO_CODE;
                    endcase
                    state_next = kpd_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = kpd_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= kpd_pkg::ST_IDLE;
            sel_reg       <= kpd_pkg::RES_ZERO;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            sel_reg       <= sel_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        code_reg <= code_next;
    end

    assign out_valid   = out_valid_reg;
    assign result_code = code_reg;

    ap_sample_decide: assert property (@(posedge clk) disable iff (!rst_n)
        (in_acc && !kind) |=> (state_reg == kpd_pkg::ST_DECIDE))
        else $error("accepted sample did not reach the decision step");

    ap_restart_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (in_acc && kind) |=> (state_reg == kpd_pkg::ST_IDLE))
        else $error("restart left the idle state");

    ap_done_load: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == kpd_pkg::ST_DONE) && out_free) |=>
        (out_valid_reg && (state_reg == kpd_pkg::ST_IDLE)))
        else $error("finished item was not loaded into the output register");

    ap_max_drain: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == kpd_pkg::ST_MAX_RD) && status.addr_last) |=>
        (state_reg == kpd_pkg::ST_MAX_DRAIN))
        else $error("maximum scan overran the store fill");

endmodule
`default_nettype wire

// File: tb/sv/tb_knock_pattern_detector_unit.sv
// Self-checking testbench of the knock pattern detector: directed table, then random knock runs.
module tb_knock_pattern_detector_unit;
    import kpd_pkg::*;

    localparam int CLK_PERIOD   = 20;
    localparam int RESET_CYCLES = 10;
    localparam int MAX_WAIT     = 14;
    localparam int DRAIN_CYCLES = 300;
    localparam int LONG_HOLD    = 600;
    localparam int MAX_REPORTS  = 10;
    localparam int N_PHASES     = 8;
    localparam int PHASE_ITEMS  = 235;
    localparam int FROM_MODEL   = -1;
    localparam int unsigned CYCLE_LIMIT = 3_000_000;

    // Indexes that decode to no register.
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

    typedef enum logic {ROW_CFG, ROW_ITEM} row_op_t;
    typedef enum logic [1:0] {RUN_LOUD, RUN_QUIET, RUN_NOISE, RUN_RESTART} run_t;

    typedef struct packed {
        row_op_t                op;
        logic [CFG_IDX_W-1:0]   reg_idx;
        logic                   knd;
        logic [CFG_DATA_W-1:0]  data;
        int                     want;
    } row_t;

    localparam int N_ROWS = 32;

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   in_valid;
    logic                   in_ready;
    logic                   kind;
    logic [SAMPLE_W-1:0]    sample;
    logic                   out_valid;
    logic                   out_ready;
    logic [7:0]             result_code;
    logic                   cfg_we;
    logic [CFG_IDX_W-1:0]   cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    // Register copies and detector state of the predictor.
    logic [WAIT_W-1:0]      wait_len;
    logic [7:0]             keep_level;
    logic [7:0]             hit_level;
    logic [7:0]             seg_len;
    logic [WAIT_W-1:0]      quiet_left;
    logic [7:0]             seg_pos;
    logic [7:0]             seg_peak;
    logic [7:0]             peak_store [STORE_DEPTH];
    int                     peak_fill;
    logic [7:0]             hit_win [WIN_LEN];

    logic [7:0]             expected_codes [$];
    logic [7:0]             want_code;
    int                     fail_count = 0;
    int                     results_checked = 0;
    int                     tx_calm = 0;
    int unsigned            cycle_count = 0;

    // Items carry a typed result where it is obvious, the rest come from the predictor.
    row_t directed_rows [N_ROWS] = '{
        '{ROW_ITEM, '0, 1'b0, 10'd0, 0},
        '{ROW_ITEM, '0, 1'b0, 10'd255, 0},
        '{ROW_ITEM, '0, 1'b0, 10'd80, 0},
        '{ROW_ITEM, '0, 1'b1, 10'd255, FROM_MODEL},
        '{ROW_CFG, CFG_SEG_LEN, 1'b0, 10'd1, FROM_MODEL},
        '{ROW_CFG, CFG_HIT_THR, 1'b0, 10'd0, FROM_MODEL},
        '{ROW_ITEM, '0, 1'b0, 10'd0, int'(HIT_CODE)},
        '{ROW_ITEM, '0, 1'b0, 10'd255, int'(HIT_CODE)},
        '{ROW_CFG, CFG_HIT_THR, 1'b0, 10'h3FF, FROM_MODEL},
        '{ROW_ITEM, '0, 1'b0, 10'd255, FROM_MODEL},
        '{ROW_ITEM, '0, 1'b0, 10'd255, FROM_MODEL},
        '{ROW_ITEM, '0, 1'b0, 10'd255, FROM_MODEL},
        '{ROW_ITEM, '0, 1'b0, 10'd255, FROM_MODEL},
        '{ROW_CFG, CFG_LISTEN_WAIT, 1'b0, 10'd0, FROM_MODEL},
        '{ROW_ITEM, '0, 1'b0, 10'd0, FROM_MODEL},
        '{ROW_ITEM, '0, 1'b0, 10'd200, FROM_MODEL},
        '{ROW_ITEM, '0, 1'b0, 10'd10, FROM_MODEL},
        '{ROW_ITEM, '0, 1'b0, 10'd255, FROM_MODEL},
        '{ROW_ITEM, '0, 1'b0, 10'd90, FROM_MODEL},
        '{ROW_CFG, CFG_KEEP_THR, 1'b0, 10'd255, FROM_MODEL},
        '{ROW_CFG, CFG_SPARE_LO, 1'b0, 10'h3FF, FROM_MODEL},
        '{ROW_CFG, CFG_SPARE_HI, 1'b0, 10'd0, FROM_MODEL},
        '{ROW_ITEM, '0, 1'b0, 10'd255, FROM_MODEL},
        '{ROW_ITEM, '0, 1'b0, 10'd0, FROM_MODEL},
        '{ROW_CFG, CFG_SEG_LEN, 1'b0, 10'd0, FROM_MODEL},
        '{ROW_CFG, CFG_LISTEN_WAIT, 1'b0, 10'd1023, FROM_MODEL},
        '{ROW_ITEM, '0, 1'b0, 10'd128, FROM_MODEL},
        '{ROW_ITEM, '0, 1'b0, 10'd1, FROM_MODEL},
        '{ROW_CFG, CFG_KEEP_THR, 1'b0, 10'd0, FROM_MODEL},
        '{ROW_ITEM, '0, 1'b0, 10'd1, FROM_MODEL},
        '{ROW_ITEM, '0, 1'b1, 10'd0, FROM_MODEL},
        '{ROW_ITEM, '0, 1'b0, 10'd64, 0}
    };

    knock_pattern_detector_unit dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .kind        (kind),
        .sample      (sample),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .result_code (result_code),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    function automatic void clear_listening();
        quiet_left = wait_len;
        seg_pos    = '0;
        seg_peak   = '0;
        for (int i = 0; i < STORE_DEPTH; i++)
            peak_store[i] = '0;
        peak_fill = int'(FILL_RST);
        for (int i = 0; i < WIN_LEN; i++)
            hit_win[i] = '0;
    endfunction

    // Counts rises between stored peaks that beat a third of the largest peak.
    function automatic logic [7:0] count_rises();
        int top;
        int th;
        int half;
        int d;
        int d2;
        int n;
        top = 0;
        n   = 0;
        for (int i = 0; i < peak_fill; i++)
            if (int'(peak_store[i]) > top)
                top = int'(peak_store[i]);
        th   = top / 3;
        half = th / 2;
        for (int i = 0; i + 1 < peak_fill; i++)
        begin
            d = int'(peak_store[i + 1]) - int'(peak_store[i]);
            if (d > half && i + 2 < peak_fill)
            begin
                d2 = int'(peak_store[i + 2]) - int'(peak_store[i + 1]);
                if (d2 > 0)
                    d += d2;
            end
            if (d > th && n < int'(KNOCK_MAX))
                n++;
        end
        return 8'(n);
    endfunction

    // Advances the predicted state by one item; returns 1 when a result is due.
    function automatic bit predict_knock_code(input logic knd, input logic [7:0] amp,
                                              output logic [7:0] code);
        logic hit;
        hit  = 1'b0;
        code = ZERO_CODE;
        if (knd)
        begin
            clear_listening();
            return 1'b0;
        end
        seg_pos = seg_pos + 8'd1;
        if (seg_pos == seg_len)
        begin
            seg_pos = '0;
            if (peak_fill < STORE_DEPTH)
            begin
                peak_store[peak_fill] = seg_peak;
                peak_fill++;
            end
            for (int i = 0; i + 1 < WIN_LEN; i++)
                hit_win[i] = hit_win[i + 1];
            hit_win[WIN_LEN - 1] = seg_peak;
            hit = 1'b1;
            for (int i = 0; i < WIN_LEN; i++)
                if (hit_win[i] < hit_level)
                    hit = 1'b0;
            seg_peak = '0;
        end
        if (amp > seg_peak)
            seg_peak = amp;
        if (amp > keep_level)
            quiet_left = wait_len;
        if (quiet_left != '0)
            quiet_left = quiet_left - 1'b1;
        if (hit)
            code = HIT_CODE;
        else if (quiet_left == '0)
            code = count_rises();
        return 1'b1;
    endfunction

    task automatic note_failure(input string what);
        fail_count++;
        if (fail_count <= MAX_REPORTS)
            $display("%s", what);
    endtask

    task automatic offer_item(input logic knd, input logic [7:0] amp, input int want);
        int gap;
        logic [7:0] code;
        if (tx_calm > 0)
        begin
            tx_calm--;
            gap = 0;
        end
        else if ($urandom_range(0, 29) == 0)
        begin
            tx_calm = $urandom_range(20, 60);
            gap = 0;
        end
        else
            gap = $urandom_range(0, MAX_WAIT);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        kind     <= knd;
        sample   <= amp;
        do
            @(posedge clk);
        while (!in_ready);
        if (predict_knock_code(knd, amp, code))
            expected_codes.push_back(want >= 0 ? 8'(want) : code);
    endtask

    // A restart leaves no result behind, so the block gets a full latency to settle.
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (expected_codes.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_LISTEN_WAIT: wait_len   = data;
            CFG_KEEP_THR:    keep_level = data[7:0];
            CFG_HIT_THR:     hit_level  = data[7:0];
            CFG_SEG_LEN:     seg_len    = data[7:0];
            default: ;
        endcase
    endtask

    initial
    begin
        rst_n <= 1'b0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("knock_pattern_detector_unit test failed");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (out_valid && out_ready)
        begin
            results_checked++;
            if (expected_codes.size() == 0)
                note_failure($sformatf("result %0d: code %0d arrived with none expected",
                                       results_checked, result_code));
            else
            begin
                want_code = expected_codes.pop_front();
                if (result_code !== want_code)
                    note_failure($sformatf("result %0d: expected code %0d, got %0d",
                                           results_checked, want_code, result_code));
            end
        end
    end

    // Result side: random stalls, calm stretches, and two long hold-offs that back up the input.
    initial
    begin : result_sink
        int hold;
        int taken;
        int calm;
        taken = 0;
        calm  = 0;
        out_ready <= 1'b0;
        wait (rst_n);
        forever
        begin
            if (taken == 150 || taken == 900)
                hold = LONG_HOLD;
            else if (calm > 0)
            begin
                calm--;
                hold = 0;
            end
            else if ($urandom_range(0, 29) == 0)
            begin
                calm = $urandom_range(20, 60);
                hold = 0;
            end
            else
                hold = $urandom_range(0, MAX_WAIT);
            if (hold > 0)
            begin
                out_ready <= 1'b0;
                repeat (hold) @(posedge clk);
            end
            out_ready <= 1'b1;
            do
                @(posedge clk);
            while (!out_valid);
            taken++;
        end
    end

    initial
    begin : stimulus
        int sent;
        int run_left;
        int pick;
        run_t run;
        in_valid  <= 1'b0;
        kind      <= 1'b0;
        sample    <= '0;
        cfg_we    <= 1'b0;
        cfg_index <= '0;
        cfg_data  <= '0;
        wait_len   = LISTEN_WAIT_RST;
        keep_level = KEEP_THR_RST;
        hit_level  = HIT_THR_RST;
        seg_len    = SEG_LEN_RST;
        clear_listening();
        run = RUN_QUIET;
        wait (rst_n);
        @(posedge clk);

        foreach (directed_rows[r])
        begin
            if (directed_rows[r].op == ROW_CFG)
            begin
                wait_idle();
                set_reg(directed_rows[r].reg_idx, directed_rows[r].data);
            end
            else
                offer_item(directed_rows[r].knd, directed_rows[r].data[7:0],
                           directed_rows[r].want);
        end

        for (int phase = 0; phase < N_PHASES; phase++)
        begin
            wait_idle();
            case (phase)
                0:
                begin
                    set_reg(CFG_LISTEN_WAIT, 10'd1023);
                    set_reg(CFG_KEEP_THR, 10'd0);
                    set_reg(CFG_HIT_THR, 10'd255);
                    set_reg(CFG_SEG_LEN, 10'd255);
                end
                1:
                begin
                    set_reg(CFG_LISTEN_WAIT, 10'd0);
                    set_reg(CFG_KEEP_THR, 10'd255);
                    set_reg(CFG_HIT_THR, 10'd0);
                    set_reg(CFG_SEG_LEN, 10'd0);
                end
                2:
                begin
                    set_reg(CFG_LISTEN_WAIT, 10'd1);
                    set_reg(CFG_KEEP_THR, 10'd128);
                    set_reg(CFG_HIT_THR, 10'd200);
                    set_reg(CFG_SEG_LEN, 10'd1);
                end
                default:
                begin
                    set_reg(CFG_LISTEN_WAIT, 10'($urandom_range(1, 48)));
                    set_reg(CFG_KEEP_THR, {2'($urandom), 8'($urandom_range(40, 160))});
                    set_reg(CFG_HIT_THR, {2'($urandom), 8'($urandom_range(60, 255))});
                    set_reg(CFG_SEG_LEN, {2'($urandom), 8'($urandom_range(1, 8))});
                end
            endcase
            set_reg(3'($urandom_range(int'(CFG_SPARE_LO), int'(CFG_SPARE_HI))), 10'($urandom));

            // Knock-like runs: loud bursts, quiet stretches that can be long enough to end listening,
            // some noise and an occasional restart.
            sent     = 0;
            run_left = 0;
            while (sent < PHASE_ITEMS)
            begin
                if (run_left == 0)
                begin
                    pick = $urandom_range(0, 99);
                    if (pick < 2)
                    begin
                        run      = RUN_RESTART;
                        run_left = 1;
                    end
                    else if (pick < 14)
                    begin
                        run      = RUN_NOISE;
                        run_left = $urandom_range(1, 16);
                    end
                    else if (pick < 55)
                    begin
                        run      = RUN_LOUD;
                        run_left = $urandom_range(1, 24);
                    end
                    else
                    begin
                        run      = RUN_QUIET;
                        run_left = $urandom_range(1, int'(wait_len) + 8);
                    end
                end
                case (run)
                    RUN_RESTART: offer_item(1'b1, 8'($urandom), FROM_MODEL);
                    RUN_NOISE:   offer_item(1'b0, 8'($urandom), FROM_MODEL);
                    RUN_LOUD:    offer_item(1'b0, 8'($urandom_range(128, 255)), FROM_MODEL);
                    default:     offer_item(1'b0, 8'($urandom_range(0, int'(keep_level))),
                                            FROM_MODEL);
                endcase
                run_left--;
                sent++;
            end
        end

        wait_idle();
        if (fail_count == 0)
            $display("knock_pattern_detector_unit test passed");
        else
            $display("knock_pattern_detector_unit test failed");
        $finish;
    end

endmodule
